// ===== rtl/ivs_pkg.sv =====
// shared types and constants for the indexed value stack
package ivs_pkg;

  localparam int unsigned DEPTH_DEF  = 64;
  localparam int unsigned WORD_W_DEF = 64;
  localparam int unsigned TAG_W      = 3;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned AMT_W      = 11;
  localparam int unsigned CMD_W      = 4;
  localparam int unsigned ERR_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 4'd0,
    CMD_POP     = 4'd1,
    CMD_PEEK    = 4'd2,
    CMD_SETD    = 4'd3,
    CMD_INSERT  = 4'd4,
    CMD_REMOVE  = 4'd5,
    CMD_REPLACE = 4'd6,
    CMD_COPY    = 4'd7,
    CMD_ROTATE  = 4'd8
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_INDEX     = 3'd3,
    ERR_DEPTH     = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    SEL_HOLD  = 3'd0,
    SEL_LEFT  = 3'd1,
    SEL_RIGHT = 3'd2,
    SEL_BUS   = 3'd3,
    SEL_IN    = 3'd4
  } sel_e;

endpackage

// ===== rtl/ivs_cell.sv =====
// one stack slot: holds a tagged word and loads from a neighbor, the bus or the input
module ivs_cell #(
  parameter int unsigned SW = ivs_pkg::WORD_W_DEF + ivs_pkg::TAG_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ivs_pkg::sel_e sel_i,
  input  logic [SW-1:0] left_i,
  input  logic [SW-1:0] right_i,
  input  logic [SW-1:0] bus_i,
  input  logic [SW-1:0] in_i,
  output logic [SW-1:0] slot_o
);

  logic [SW-1:0] slot_q, slot_d;

  always_comb begin
    unique case (sel_i)
      ivs_pkg::SEL_LEFT:  slot_d = left_i;
      ivs_pkg::SEL_RIGHT: slot_d = right_i;
      ivs_pkg::SEL_BUS:   slot_d = bus_i;
      ivs_pkg::SEL_IN:    slot_d = in_i;
      default:            slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== rtl/indexed_value_stack_unit.sv =====
// indexed value stack: controller, remainder unit and the row of slot cells
//
//   channel | valid      | ready      | fields
//   in      | in_valid_i | in_ready_o | command, index, second_index, rotate_amount, value
//   out     | out_valid_o| out_ready_i| data_word, data_tag, depth, error
//
// most commands: the idle state takes the request, the exec state executes it in the cells
// rotate adds 11 remainder steps in the div state, then one rot step per position moved
// (at most count-1) and the done state to post the result
// reset clears every slot to nil and the depth to zero, no clearing pass
// a waiting result holds execution; a new request is taken while it waits
module indexed_value_stack_unit #(
  parameter int unsigned DEPTH      = ivs_pkg::DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = ivs_pkg::WORD_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ivs_pkg::CMD_W-1:0]           command_i,
  input  logic signed [ivs_pkg::IDX_W-1:0]    index_i,
  input  logic signed [ivs_pkg::IDX_W-1:0]    second_index_i,
  input  logic signed [ivs_pkg::AMT_W-1:0]    rotate_amount_i,
  input  logic [WORD_WIDTH-1:0]               value_word_i,
  input  logic [ivs_pkg::TAG_W-1:0]           value_tag_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [WORD_WIDTH-1:0]               data_word_o,
  output logic [ivs_pkg::TAG_W-1:0]           data_tag_o,
  output logic [$clog2(DEPTH+1)-1:0]          depth_o,
  output logic [ivs_pkg::ERR_W-1:0]           error_o
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = WORD_WIDTH + ivs_pkg::TAG_W;
  localparam int unsigned IW    = ((CW > ivs_pkg::IDX_W) ? CW : ivs_pkg::IDX_W) + 2;
  localparam int unsigned AMT_W = ivs_pkg::AMT_W;
  localparam int unsigned NW    = $clog2(AMT_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ROT  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // latched request
  ivs_pkg::cmd_e                   cmd_q;
  logic signed [ivs_pkg::IDX_W-1:0] idx_q, idx2_q;
  logic signed [AMT_W-1:0]         amt_q;
  logic [WORD_WIDTH-1:0]           word_q;
  logic [ivs_pkg::TAG_W-1:0]       tag_q;

  logic [CW-1:0]    top_q, top_d;
  logic [AMT_W-1:0] div_a_q;
  logic [CW-1:0]    rem_q, count_q, steps_q;
  logic [NW-1:0]    cnt_q;
  logic [AW-1:0]    base_q;
  logic             up_q;

  logic                      out_valid_q;
  logic [WORD_WIDTH-1:0]     data_word_q;
  logic [ivs_pkg::TAG_W-1:0] data_tag_q;
  logic [CW-1:0]             depth_q;
  ivs_pkg::err_e             err_q;

  logic [SW-1:0] slot [DEPTH];
  logic [SW-1:0] bus;
  logic [SW-1:0] in_slot;
  logic [AW-1:0] bus_idx;
  logic [AW-1:0] tm1_u;
  logic [DEPTH-1:0] move_v;

  logic signed [IW-1:0] top_s, idx_s, idx2_s, r_s, r2_s, ri_s, base_s;
  logic r_ok, r2_ok, ins_ok;
  logic out_free, rot_go, commit, rot_step, res_we;
  logic do_push, do_ins, do_rem, do_rep, do_copy, rd_en;
  ivs_pkg::err_e err_c;
  logic [AMT_W-1:0] amt_abs;
  logic [CW:0]      div_t, div_n;

  // index resolution
  always_comb begin
    top_s  = IW'(top_q);
    idx_s  = IW'(idx_q);
    idx2_s = IW'(idx2_q);
    base_s = IW'(base_q);
    r_s    = (idx_s < 0) ? top_s + idx_s : idx_s;
    r2_s   = (idx2_s < 0) ? top_s + idx2_s : idx2_s;
    ri_s   = (idx_s < 0) ? top_s + idx_s + IW'(1) : idx_s;
    r_ok   = (r_s >= 0) && (r_s < top_s);
    r2_ok  = (r2_s >= 0) && (r2_s < top_s);
    ins_ok = (top_q != '0) && (ri_s >= 0) && (ri_s <= top_s);
  end

  assign tm1_u    = AW'(top_q - CW'(1));
  assign out_free = !out_valid_q || out_ready_i;
  assign rot_go   = (cmd_q == ivs_pkg::CMD_ROTATE) && r_ok && (amt_q != '0);
  assign commit   = (state_q == ST_EXEC) && !rot_go && out_free;
  assign rot_step = (state_q == ST_ROT);
  assign res_we   = commit || ((state_q == ST_DONE) && out_free);
  assign amt_abs  = amt_q[AMT_W-1] ? (~amt_q + 1'b1) : amt_q;
  assign in_slot  = {tag_q, word_q};

  // command decode
  always_comb begin
    err_c   = ivs_pkg::ERR_OK;
    top_d   = top_q;
    do_push = 1'b0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_rep  = 1'b0;
    do_copy = 1'b0;
    rd_en   = 1'b0;
    bus_idx = tm1_u;
    unique case (cmd_q)
      ivs_pkg::CMD_PUSH: begin
        if (top_q == CW'(DEPTH)) begin
          err_c = ivs_pkg::ERR_OVERFLOW;
        end else begin
          do_push = 1'b1;
          top_d   = top_q + CW'(1);
        end
      end
      ivs_pkg::CMD_POP: begin
        if (top_q == '0) begin
          err_c = ivs_pkg::ERR_UNDERFLOW;
        end else begin
          rd_en = 1'b1;
          top_d = top_q - CW'(1);
        end
      end
      ivs_pkg::CMD_PEEK: begin
        if (!r_ok) begin
          err_c = ivs_pkg::ERR_INDEX;
        end else begin
          rd_en   = 1'b1;
          bus_idx = r_s[AW-1:0];
        end
      end
      ivs_pkg::CMD_SETD: begin
        if (idx_s < 0 || idx_s > IW'(DEPTH)) begin
          err_c = ivs_pkg::ERR_DEPTH;
        end else begin
          top_d = idx_s[CW-1:0];
        end
      end
      ivs_pkg::CMD_INSERT: begin
        if (!ins_ok) begin
          err_c = ivs_pkg::ERR_INDEX;
        end else begin
          do_ins = (ri_s < top_s);
        end
      end
      ivs_pkg::CMD_REMOVE: begin
        if (!r_ok) begin
          err_c = ivs_pkg::ERR_INDEX;
        end else begin
          do_rem = 1'b1;
          top_d  = top_q - CW'(1);
        end
      end
      ivs_pkg::CMD_REPLACE: begin
        if (!r_ok) begin
          err_c = ivs_pkg::ERR_INDEX;
        end else begin
          do_rep = 1'b1;
          top_d  = top_q - CW'(1);
        end
      end
      ivs_pkg::CMD_COPY: begin
        if (!(r_ok && r2_ok)) begin
          err_c = ivs_pkg::ERR_INDEX;
        end else begin
          do_copy = 1'b1;
          bus_idx = r_s[AW-1:0];
        end
      end
      default: ;
    endcase
    if (rot_step) begin
      bus_idx = up_q ? tm1_u : base_q;
    end
  end

  assign bus = slot[bus_idx];

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic signed [IW-1:0] CI = IW'(i);
    ivs_pkg::sel_e cell_sel;
    logic [SW-1:0] lft, rgt;

    if (i == 0) begin : g_l0
      assign lft = '0;
    end else begin : g_l
      assign lft = slot[i-1];
    end
    if (i == DEPTH - 1) begin : g_rn
      assign rgt = '0;
    end else begin : g_r
      assign rgt = slot[i+1];
    end

    always_comb begin
      cell_sel = ivs_pkg::SEL_HOLD;
      if (commit) begin
        if (do_push && CI == top_s) cell_sel = ivs_pkg::SEL_IN;
        if (do_ins) begin
          if (CI == ri_s) cell_sel = ivs_pkg::SEL_BUS;
          else if (CI > ri_s && CI < top_s) cell_sel = ivs_pkg::SEL_LEFT;
        end
        if (do_rem && CI >= r_s && CI < top_s - IW'(1)) cell_sel = ivs_pkg::SEL_RIGHT;
        if (do_rep && CI == r_s) cell_sel = ivs_pkg::SEL_BUS;
        if (do_copy && CI == r2_s) cell_sel = ivs_pkg::SEL_BUS;
      end else if (rot_step) begin
        if (up_q) begin
          if (CI == base_s) cell_sel = ivs_pkg::SEL_BUS;
          else if (CI > base_s && CI < top_s) cell_sel = ivs_pkg::SEL_LEFT;
        end else begin
          if (CI == top_s - IW'(1)) cell_sel = ivs_pkg::SEL_BUS;
          else if (CI >= base_s && CI < top_s - IW'(1)) cell_sel = ivs_pkg::SEL_RIGHT;
        end
      end
    end

    assign move_v[i] = (cell_sel != ivs_pkg::SEL_HOLD);

    ivs_cell #(.SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sel_i   (cell_sel),
      .left_i  (lft),
      .right_i (rgt),
      .bus_i   (bus),
      .in_i    (in_slot),
      .slot_o  (slot[i])
    );
  end

  // remainder step
  assign div_t = {rem_q, div_a_q[AMT_W-1]};
  assign div_n = (div_t >= {1'b0, count_q}) ? div_t - {1'b0, count_q} : div_t;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (rot_go) state_d = ST_DIV;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (cnt_q == NW'(AMT_W - 1)) begin
          state_d = (div_n == '0) ? ST_DONE : ST_ROT;
        end
      end
      ST_ROT:  if (steps_q == CW'(1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      steps_q     <= '0;
    end else begin
      state_q <= state_d;
      if (commit) top_q <= top_d;
      if (res_we) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_EXEC) cnt_q <= '0;
      else if (state_q == ST_DIV) cnt_q <= cnt_q + NW'(1);
      if (state_q == ST_DIV) steps_q <= div_n[CW-1:0];
      else if (rot_step) steps_q <= steps_q - CW'(1);
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= ivs_pkg::cmd_e'(command_i);
      idx_q  <= index_i;
      idx2_q <= second_index_i;
      amt_q  <= rotate_amount_i;
      word_q <= value_word_i;
      tag_q  <= value_tag_i;
    end
    if (state_q == ST_EXEC) begin
      div_a_q <= amt_abs;
      rem_q   <= '0;
      count_q <= top_q - r_s[CW-1:0];
      base_q  <= r_s[AW-1:0];
      up_q    <= !amt_q[AMT_W-1];
    end else if (state_q == ST_DIV) begin
      div_a_q <= div_a_q << 1;
      rem_q   <= div_n[CW-1:0];
    end
    if (res_we) begin
      if (commit && rd_en) begin
        data_word_q <= bus[WORD_WIDTH-1:0];
        data_tag_q  <= bus[SW-1:WORD_WIDTH];
      end else begin
        data_word_q <= '0;
        data_tag_q  <= '0;
      end
      depth_q <= commit ? top_d : top_q;
      err_q   <= commit ? err_c : ivs_pkg::ERR_OK;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign data_word_o = data_word_q;
  assign data_tag_o  = data_tag_q;
  assign depth_o     = depth_q;
  assign error_o     = err_q;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= CW'(DEPTH)) else $error("depth above capacity");
  a_take_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EXEC) else $error("request not executed");
  a_cells_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_EXEC && state_q != ST_ROT) |-> move_v == '0)
    else $error("slot moved outside execution");
`endif

endmodule
